// ----- sv/ppdb_pkg.sv -----
package ppdb_pkg;

    // Field and datapath widths
    localparam int COORD_WIDTH   = 24;
    localparam int CORDIC_STAGES = 24;
    localparam int GUARD_BITS    = 4;
    localparam int DEG_FRAC      = 24;
    localparam int DIFF_W        = COORD_WIDTH + 1;
    // |v| * CORDIC gain stays below 2^(COORD_WIDTH + GUARD_BITS + 2)
    localparam int XW            = COORD_WIDTH + GUARD_BITS + 4;
    // angle accumulator spans about -100..280 degrees
    localparam int ZW            = DEG_FRAC + 10;
    localparam int PW            = (XW - 1) + 32;
    localparam int D1_W          = PW - 32;
    localparam int BQ_W          = ZW - 8;
    localparam int DIST_W        = 26;
    localparam int BEAR_W        = 25;

    localparam logic [31:0]           INV_GAIN_Q32 = 32'h9B74EDA8;
    localparam logic [63:0]           RAD2DEG_Q24  = 64'd961263669;
    localparam logic signed [ZW-1:0]  Z_HALF_TURN  = ZW'(64'd180 << DEG_FRAC);
    localparam logic signed [ZW-1:0]  Z_ROUND      = ZW'(128);
    localparam logic [PW-1:0]         PROD_ROUND   = PW'(64'd1 << 31);
    localparam logic signed [BQ_W-1:0] BQ_FULL     = BQ_W'(360 * 65536);
    localparam logic [BEAR_W-1:0]     BEAR_90      = BEAR_W'(90 * 65536);
    localparam logic [BEAR_W-1:0]     BEAR_180     = BEAR_W'(180 * 65536);
    localparam logic [BEAR_W-1:0]     BEAR_270     = BEAR_W'(270 * 65536);
    localparam logic [BEAR_W-1:0]     BEAR_FULL    = BEAR_W'(360 * 65536);
    localparam logic [DIST_W-1:0]     DIST_MAX     = '1;

    // How the final bearing is chosen
    typedef enum logic [2:0] {
        BSEL_CORDIC,
        BSEL_ZERO,
        BSEL_90,
        BSEL_180,
        BSEL_270
    } ppdb_bear_sel_t;

    typedef struct packed {
        logic           coincident;
        ppdb_bear_sel_t bear_sel;
    } ppdb_side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        ppdb_side_t           side;
    } ppdb_vec_t;

    // Restoring divide, elaboration only (angle table)
    function automatic logic [63:0] udiv_restoring(input logic [63:0] num,
                                                   input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in degrees Q24: Taylor series in Q60, rounded to Q32 radians,
    // then scaled by 180/pi in Q24 with rounding.
    function automatic logic [63:0] atan_deg_q24(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rad32;
        int          sh;
        sum = '0;
        if (i == 0) begin
            return 64'd45 << DEG_FRAC;
        end
        for (int k = 0; k < 31; k++) begin
            sh = i * (2 * k + 1);
            if (sh <= 60) begin
                term = udiv_restoring((64'd1 << 60) >> sh, 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end
                else begin
                    sum = sum + term;
                end
            end
        end
        rad32 = (sum + (64'd1 << 27)) >> 28;
        return (rad32 * RAD2DEG_Q24 + (64'd1 << 31)) >> 32;
    endfunction

endpackage

// ----- sv/ppdb_pair_if.sv -----
interface ppdb_pair_if import ppdb_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;

    modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                    input ready);
    modport sink (input valid, input from_x, input from_y, input to_x, input to_y,
                  output ready);
endinterface

// ----- sv/ppdb_result_if.sv -----
interface ppdb_result_if import ppdb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic [BEAR_W-1:0] bearing_deg;
    logic              coincident;

    modport source (output valid, output distance, output bearing_deg, output coincident,
                    input ready);
    modport sink (input valid, input distance, input bearing_deg, input coincident,
                  output ready);
endinterface

// ----- sv/ppdb_cordic.sv -----
module ppdb_cordic import ppdb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ppdb_vec_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ppdb_vec_t out_data
);

    ppdb_vec_t vec_reg   [CORDIC_STAGES];
    logic      valid_reg [CORDIC_STAGES];
    logic      load      [CORDIC_STAGES+1];

    assign load[CORDIC_STAGES] = out_ready;

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(atan_deg_q24(s));

        ppdb_vec_t            src;
        logic                 src_valid;
        ppdb_vec_t            vec_next;
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] z_in;
        logic                 y_pos;

        if (s == 0)
        begin : g_first
            assign src       = in_data;
            assign src_valid = in_valid;
        end
        else
        begin : g_chain
            assign src       = vec_reg[s-1];
            assign src_valid = valid_reg[s-1];
        end

        // stage takes new data when empty or when its contents move on
        assign load[s] = !valid_reg[s] || load[s+1];

        always_comb
        begin
            x_in  = src.x;
            y_in  = src.y;
            z_in  = src.z;
            xs    = x_in >>> s;
            ys    = y_in >>> s;
            y_pos = !y_in[XW-1] && (y_in != '0);
            vec_next.side = src.side;
            if (y_pos)
            begin
                vec_next.x = x_in + ys;
                vec_next.y = y_in - xs;
                vec_next.z = z_in + ANG;
            end
            else
            begin
                vec_next.x = x_in - ys;
                vec_next.y = y_in + xs;
                vec_next.z = z_in - ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (load[s])
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[s] && src_valid)
            begin
                vec_reg[s] <= vec_next;
            end
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_data  = vec_reg[CORDIC_STAGES-1];

endmodule

// ----- sv/point_pair_distance_and_bearing_top.sv -----
// Distance and bearing between two points, signed Q16.8 coordinates.
//
// Channels: "pair" (sink) takes from_x, from_y, to_x, to_y; "result"
// (source) gives distance (Q18.8), bearing_deg (Q9.16, [0,360)) and
// coincident. A request moves when valid and ready are both high.
//
// Throughput: one request per cycle, sustained while "result" is ready.
// Pipeline: a request taken on "pair" passes one prep stage, 24 CORDIC
// vectoring stages, a gain multiply, a rounding stage and the output
// register before its result shows on "result"; most stages are CORDIC.
//
// Stall: every stage has its own valid bit and loads when empty or when its
// contents move on, so bubbles close up while "result" is held off and new
// requests are still taken until the pipe is full. Nothing is lost or
// repeated; the output register holds its values while ready is low.
//
// Reset (rst_n low, async): all valid bits clear, the pipe is empty and
// "pair" ready is high. Coincident points give distance 0, bearing 0.
module point_pair_distance_and_bearing_top import ppdb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    ppdb_pair_if.sink     pair,
    ppdb_result_if.source result
);

    // ---------------------------------------------------------------
    // Prep stage: differences, half-plane fold, special-case flags
    // ---------------------------------------------------------------
    ppdb_vec_t p_vec_reg;
    ppdb_vec_t p_vec_next;
    logic      p_valid_reg;
    logic      p_load;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ndx;
    logic signed [DIFF_W-1:0] ndy;
    logic                     dx_zero;
    logic                     dy_zero;

    // CORDIC chain handshake
    logic      cor_in_ready;
    logic      cor_out_valid;
    ppdb_vec_t cor_out_data;

    // Gain multiply stage
    logic [PW-1:0]          m_prod_reg;
    logic [PW-1:0]          m_prod_next;
    logic signed [BQ_W-1:0] m_bq_reg;
    logic signed [BQ_W-1:0] m_bq_next;
    ppdb_side_t             m_side_reg;
    logic                   m_valid_reg;
    logic                   m_load;
    logic [XW-2:0]          x_mag;
    logic signed [ZW-1:0]   z_rnd;

    // Rounding / bearing select stage
    logic [D1_W-1:0]   r_d1_reg;
    logic [D1_W-1:0]   r_d1_next;
    logic [BEAR_W-1:0] r_bear_reg;
    logic [BEAR_W-1:0] r_bear_next;
    logic              r_coinc_reg;
    logic              r_valid_reg;
    logic              r_load;
    logic [PW-1:0]     prod_rnd;
    logic signed [BQ_W-1:0] bq_wrap;

    // Output register
    logic [DIST_W-1:0] o_dist_reg;
    logic [DIST_W-1:0] o_dist_next;
    logic [BEAR_W-1:0] o_bear_reg;
    logic              o_coinc_reg;
    logic              o_valid_reg;
    logic              o_load;
    logic [D1_W:0]     d2_sum;
    logic [D1_W-GUARD_BITS:0] d2;

    // ready chain, back to front
    assign o_load     = !o_valid_reg || result.ready;
    assign r_load     = !r_valid_reg || o_load;
    assign m_load     = !m_valid_reg || r_load;
    assign p_load     = !p_valid_reg || cor_in_ready;
    assign pair.ready = p_load;

    always_comb
    begin
        dx      = DIFF_W'(pair.to_x) - DIFF_W'(pair.from_x);
        dy      = DIFF_W'(pair.to_y) - DIFF_W'(pair.from_y);
        ndx     = DIFF_W'(pair.from_x) - DIFF_W'(pair.to_x);
        ndy     = DIFF_W'(pair.from_y) - DIFF_W'(pair.to_y);
        dx_zero = (pair.to_x == pair.from_x);
        dy_zero = (pair.to_y == pair.from_y);

        // left half-plane: rotate by 180 degrees up front
        if (dx[DIFF_W-1])
        begin
            p_vec_next.x = XW'(ndx) <<< GUARD_BITS;
            p_vec_next.y = XW'(ndy) <<< GUARD_BITS;
            p_vec_next.z = Z_HALF_TURN;
        end
        else
        begin
            p_vec_next.x = XW'(dx) <<< GUARD_BITS;
            p_vec_next.y = XW'(dy) <<< GUARD_BITS;
            p_vec_next.z = '0;
        end

        p_vec_next.side.coincident = dx_zero && dy_zero;
        if (dx_zero && dy_zero)
        begin
            p_vec_next.side.bear_sel = BSEL_ZERO;
        end
        else if (dy_zero)
        begin
            p_vec_next.side.bear_sel = dx[DIFF_W-1] ? BSEL_180 : BSEL_ZERO;
        end
        else if (dx_zero)
        begin
            p_vec_next.side.bear_sel = dy[DIFF_W-1] ? BSEL_270 : BSEL_90;
        end
        else
        begin
            p_vec_next.side.bear_sel = BSEL_CORDIC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_load)
        begin
            p_valid_reg <= pair.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load && pair.valid)
        begin
            p_vec_reg <= p_vec_next;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC vectoring chain
    // ---------------------------------------------------------------
    ppdb_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_ready  (cor_in_ready),
        .in_data   (p_vec_reg),
        .out_valid (cor_out_valid),
        .out_ready (m_load),
        .out_data  (cor_out_data)
    );

    // ---------------------------------------------------------------
    // Gain multiply; angle rounded to Q16
    // ---------------------------------------------------------------
    always_comb
    begin
        x_mag       = cor_out_data.x[XW-1] ? '0 : cor_out_data.x[XW-2:0];
        m_prod_next = PW'(x_mag) * PW'(INV_GAIN_Q32);
        z_rnd       = cor_out_data.z + Z_ROUND;
        m_bq_next   = z_rnd[ZW-1:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_load)
        begin
            m_valid_reg <= cor_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load && cor_out_valid)
        begin
            m_prod_reg <= m_prod_next;
            m_bq_reg   <= m_bq_next;
            m_side_reg <= cor_out_data.side;
        end
    end

    // ---------------------------------------------------------------
    // Drop Q32 fraction of the product; wrap and pick the bearing
    // ---------------------------------------------------------------
    always_comb
    begin
        prod_rnd  = m_prod_reg + PROD_ROUND;
        r_d1_next = prod_rnd[PW-1:32];

        if (m_bq_reg[BQ_W-1])
        begin
            bq_wrap = m_bq_reg + BQ_FULL;
        end
        else if (m_bq_reg >= BQ_FULL)
        begin
            bq_wrap = m_bq_reg - BQ_FULL;
        end
        else
        begin
            bq_wrap = m_bq_reg;
        end

        case (m_side_reg.bear_sel)
            BSEL_CORDIC: r_bear_next = bq_wrap[BEAR_W-1:0];
            BSEL_ZERO:   r_bear_next = '0;
            BSEL_90:     r_bear_next = BEAR_90;
            BSEL_180:    r_bear_next = BEAR_180;
            BSEL_270:    r_bear_next = BEAR_270;
            default:     r_bear_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (r_load)
        begin
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load && m_valid_reg)
        begin
            r_d1_reg    <= r_d1_next;
            r_bear_reg  <= r_bear_next;
            r_coinc_reg <= m_side_reg.coincident;
        end
    end

    // ---------------------------------------------------------------
    // Remove guard bits with rounding, saturate, register out
    // ---------------------------------------------------------------
    always_comb
    begin
        d2_sum = (D1_W + 1)'(r_d1_reg) + (D1_W + 1)'(1 << (GUARD_BITS - 1));
        d2     = d2_sum[D1_W:GUARD_BITS];
        if (r_coinc_reg)
        begin
            o_dist_next = '0;
        end
        else if (d2 > (D1_W - GUARD_BITS + 1)'(DIST_MAX))
        begin
            o_dist_next = DIST_MAX;
        end
        else
        begin
            o_dist_next = d2[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_load)
        begin
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load && r_valid_reg)
        begin
            o_dist_reg  <= o_dist_next;
            o_bear_reg  <= r_bear_reg;
            o_coinc_reg <= r_coinc_reg;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.distance    = o_dist_reg;
    assign result.bearing_deg = o_bear_reg;
    assign result.coincident  = o_coinc_reg;

endmodule

// ----- sv/ppdb_checker.sv -----
module ppdb_checker import ppdb_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              pair_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [DIST_W-1:0] result_distance,
    input logic [BEAR_W-1:0] result_bearing,
    input logic              result_coincident
);

    // held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_distance)
            && $stable(result_bearing) && $stable(result_coincident))
        else $error("result changed while stalled");

    // coincident points report zero distance and bearing
    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_coincident |-> result_distance == '0
            && result_bearing == '0)
        else $error("coincident result not zero");

    a_bear_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_bearing < BEAR_FULL)
        else $error("bearing out of range");

    // a draining output means every stage can move
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> pair_ready)
        else $error("input blocked while output drains");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind point_pair_distance_and_bearing_top ppdb_checker u_ppdb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .pair_ready        (pair.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_distance   (result.distance),
    .result_bearing    (result.bearing_deg),
    .result_coincident (result.coincident)
);
